// File: src/radix_conversion_digit_emitter_unit_defines.svh
// Assertion helpers, clocked on i_clk, disabled while i_rst_n is low.
`ifndef RADIX_CONVERSION_DIGIT_EMITTER_UNIT_DEFINES_SVH
`define RADIX_CONVERSION_DIGIT_EMITTER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define RCDE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rcde assertion failed");

// Next-cycle implication.
`define RCDE_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rcde assertion failed");

`endif

// File: src/rcde_pkg.sv
package rcde_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int STACK_DEPTH = 32;
    localparam int RADIX_W     = 5;
    localparam int DIGIT_W     = 4;
    localparam int CHAR_W      = 7;

    localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);

    localparam logic [CHAR_W-1:0] CHAR_ZERO   = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] CHAR_LETTER = CHAR_W'(55);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_POP,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic start;
    } t_div_ctrl;

    typedef struct packed {
        logic               done;
        logic               quot_nz;
        logic [DIGIT_W-1:0] rem;
    } t_div_stat;

    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        res = r;
        if (r < RADIX_MIN) res = RADIX_MIN;
        if (r > RADIX_MAX) res = RADIX_MAX;
        return res;
    endfunction

    function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DIGIT_W'(10)) c = CHAR_ZERO + CHAR_W'(d);
        else                  c = CHAR_LETTER + CHAR_W'(d);
        return c;
    endfunction

endpackage

// File: src/radix_conversion_digit_emitter_unit.sv
// Radix conversion digit emitter.
// Input channel: i_in_valid / o_in_stall carry i_value and i_base (2..16;
// lower bases count as 2, higher as 16). A transfer happens on a clock edge
// with valid high and stall low. Output channel: o_out_valid / i_out_stall
// carry o_digit_char (ASCII '0'-'9', 'A'-'F') and o_last, one transfer per
// digit, most significant digit first, o_last set on the least significant.
// A zero value gives a single '0'.
// Each digit is found by a bit-serial divider; the digits then leave the
// stack RAM one at a time, each by one RAM read and one load of the
// output register. One item is in work at a time; o_in_stall is low
// only while the block is idle, including while the last digit still
// waits in the output register.
// A stalled receiver holds the output register and pauses the digit pops.
// Reset (synchronous, active low) returns the block to idle and drops any
// pending output; the stack RAM needs no clearing.
`include "radix_conversion_digit_emitter_unit_defines.svh"

module radix_conversion_digit_emitter_unit #(
    parameter int VALUE_WIDTH = rcde_pkg::VALUE_WIDTH,
    parameter int STACK_DEPTH = rcde_pkg::STACK_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [VALUE_WIDTH-1:0]       i_value,
    input  logic [rcde_pkg::RADIX_W-1:0] i_base,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [rcde_pkg::CHAR_W-1:0]  o_digit_char,
    output logic                         o_last
);

    localparam int AW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNTW = $clog2(STACK_DEPTH + 1);

    rcde_pkg::t_state              r_state, n_state;
    logic [CNTW-1:0]               r_count, n_count;
    logic                          r_out_valid, n_out_valid;
    logic [rcde_pkg::CHAR_W-1:0]   r_digit_char, n_digit_char;
    logic                          r_last, n_last;

    rcde_pkg::t_div_ctrl           w_ctrl;
    rcde_pkg::t_div_stat           w_stat;
    logic                          w_we;
    logic                          w_re;
    logic [CNTW-1:0]               w_pop_idx;
    logic [rcde_pkg::DIGIT_W-1:0]  w_rdata;
    logic                          w_out_free;

    assign w_pop_idx  = r_count - CNTW'(1);
    assign w_out_free = !r_out_valid || !i_out_stall;

    rcde_divider #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_ctrl),
        .i_dividend (i_value),
        .i_radix    (rcde_pkg::clamp_radix(i_base)),
        .o_stat     (w_stat)
    );

    rcde_ram #(
        .WIDTH(rcde_pkg::DIGIT_W),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (w_stat.rem),
        .i_re    (w_re),
        .i_raddr (w_pop_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_out_valid  = r_out_valid;
        n_digit_char = r_digit_char;
        n_last       = r_last;
        w_ctrl       = '0;
        w_we         = 1'b0;
        w_re         = 1'b0;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            rcde_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    w_ctrl.load = 1'b1;
                    n_count     = '0;
                    n_state     = rcde_pkg::S_DIV;
                end
            end
            rcde_pkg::S_DIV: begin
                if (w_stat.done) begin
                    if (r_count < CNTW'(STACK_DEPTH)) begin
                        w_we    = 1'b1;
                        n_count = r_count + CNTW'(1);
                    end
                    if (w_stat.quot_nz) begin
                        w_ctrl.start = 1'b1;
                    end else begin
                        n_state = rcde_pkg::S_POP;
                    end
                end
            end
            rcde_pkg::S_POP: begin
                w_re    = 1'b1;
                n_count = w_pop_idx;
                n_state = rcde_pkg::S_EMIT;
            end
            rcde_pkg::S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_digit_char = rcde_pkg::glyph(w_rdata);
                    n_last       = (r_count == '0);
                    n_state      = (r_count == '0) ? rcde_pkg::S_IDLE : rcde_pkg::S_POP;
                end
            end
            default: begin
                n_state = rcde_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rcde_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_digit_char <= n_digit_char;
        r_last       <= n_last;
    end

    assign o_in_stall   = (r_state != rcde_pkg::S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_digit_char = r_digit_char;
    assign o_last       = r_last;

    `RCDE_ASSERT_NXT(a_accept_starts_div, i_in_valid && !o_in_stall,
        r_state == rcde_pkg::S_DIV && r_count == '0)
    `RCDE_ASSERT_IMP(a_pop_nonempty, r_state == rcde_pkg::S_POP, r_count != '0)
    `RCDE_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CNTW'(STACK_DEPTH))
    `RCDE_ASSERT_IMP(a_done_in_div, w_stat.done, r_state == rcde_pkg::S_DIV)

endmodule

// File: src/rcde_ram.sv
module rcde_ram #(
    parameter  int WIDTH = 4,
    parameter  int DEPTH = 32,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/rcde_divider.sv
module rcde_divider #(
    parameter int VALUE_WIDTH = rcde_pkg::VALUE_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rcde_pkg::t_div_ctrl         i_ctrl,
    input  logic [VALUE_WIDTH-1:0]      i_dividend,
    input  logic [rcde_pkg::RADIX_W-1:0] i_radix,
    output rcde_pkg::t_div_stat         o_stat
);

    localparam int CW = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

    logic [VALUE_WIDTH-1:0]          r_quot, n_quot;
    logic [rcde_pkg::DIGIT_W-1:0]    r_rem, n_rem;
    logic [rcde_pkg::RADIX_W-1:0]    r_radix, n_radix;
    logic [CW-1:0]                   r_cnt, n_cnt;
    logic                            r_busy, n_busy;
    logic                            r_done, n_done;
    logic                            r_nz, n_nz;
    logic [rcde_pkg::RADIX_W-1:0]    w_trial;
    logic                            w_ge;

    // restoring division, one quotient bit per cycle
    assign w_trial = {r_rem, r_quot[VALUE_WIDTH-1]};
    assign w_ge    = (w_trial >= r_radix);

    always_comb begin
        n_quot  = r_quot;
        n_rem   = r_rem;
        n_radix = r_radix;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_nz    = r_nz;
        if (i_ctrl.load) begin
            n_quot  = i_dividend;
            n_radix = i_radix;
            n_rem   = '0;
            n_cnt   = '0;
            n_busy  = 1'b1;
            n_nz    = 1'b0;
        end else if (i_ctrl.start) begin
            n_rem   = '0;
            n_cnt   = '0;
            n_busy  = 1'b1;
            n_nz    = 1'b0;
        end else if (r_busy) begin
            n_rem  = w_ge ? rcde_pkg::DIGIT_W'(w_trial - r_radix)
                          : rcde_pkg::DIGIT_W'(w_trial);
            n_quot = {r_quot[VALUE_WIDTH-2:0], w_ge};
            n_nz   = r_nz | w_ge;
            n_cnt  = r_cnt + CW'(1);
            if (r_cnt == CW'(VALUE_WIDTH - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quot  <= n_quot;
        r_rem   <= n_rem;
        r_radix <= n_radix;
        r_nz    <= n_nz;
    end

    assign o_stat.done    = r_done;
    assign o_stat.quot_nz = r_nz;
    assign o_stat.rem     = r_rem;

endmodule

// File: tb/sv/radix_conversion_digit_emitter_unit_test.sv
module radix_conversion_digit_emitter_unit_test;

    localparam int VW             = rcde_pkg::VALUE_WIDTH;
    localparam int RW             = rcde_pkg::RADIX_W;
    localparam int CW             = rcde_pkg::CHAR_W;
    localparam int ITEMS_PER_PASS = 75;
    localparam int HOLD_CYCLES    = 1500;
    localparam int TAIL_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 20000;

    class digit_scoreboard;
        typedef struct packed {
            logic [CW-1:0] ch;
            logic          last;
        } t_digit;

        localparam logic [CW-1:0] ASCII_ZERO    = 7'h30;
        localparam logic [CW-1:0] ASCII_UPPER_A = 7'h41;

        t_digit pending_digits[$];
        int     mismatches;
        int     checked;

        function new();
            mismatches = 0;
            checked    = 0;
        endfunction

        function int pending();
            return pending_digits.size();
        endfunction

        // Repeated division; remainders collected least significant first.
        function void note_conversion(logic [VW-1:0] value, logic [RW-1:0] base);
            logic [VW-1:0] quot;
            logic [RW-1:0] radix;
            logic [3:0]    digits[$];
            logic [3:0]    d;
            t_digit        e;
            radix = base;
            if (base < 2) radix = 2;
            if (base > 16) radix = 16;
            quot = value;
            do begin
                if (digits.size() < rcde_pkg::STACK_DEPTH) digits.push_back(4'(quot % radix));
                quot = quot / radix;
            end while (quot != 0);
            for (int i = digits.size() - 1; i >= 0; i--) begin
                d = digits[i];
                if (d < 10) e.ch = ASCII_ZERO + CW'(d);
                else        e.ch = ASCII_UPPER_A + CW'(d - 4'd10);
                e.last = (i == 0);
                pending_digits.push_back(e);
            end
        endfunction

        task report_mismatch(string what);
            $display("mismatch @%0t: %s", $time, what);
            mismatches++;
        endtask

        task check_digit(logic [CW-1:0] ch, logic last);
            t_digit e;
            checked++;
            if (pending_digits.size() == 0) begin
                report_mismatch($sformatf("unexpected digit 0x%02h last=%0b", ch, last));
                return;
            end
            e = pending_digits.pop_front();
            if (ch !== e.ch)
                report_mismatch($sformatf("digit 0x%02h, want 0x%02h", ch, e.ch));
            if (last !== e.last)
                report_mismatch($sformatf("last %0b, want %0b", last, e.last));
        endtask
    endclass

    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          i_in_valid  = 1'b0;
    logic [VW-1:0] i_value     = '0;
    logic [RW-1:0] i_base      = '0;
    logic          i_out_stall = 1'b0;
    logic          o_in_stall;
    logic          o_out_valid;
    logic [CW-1:0] o_digit_char;
    logic          o_last;

    digit_scoreboard sb;
    int            send_idle_pct = 0;
    int            stall_pct     = 0;
    int            hold_left     = 0;
    bit            hold_req      = 1'b0;
    int            holds_done    = 0;
    int            items_sent    = 0;
    int            quiet         = 0;

    wire in_xfer  = i_in_valid && !o_in_stall;
    wire out_xfer = o_out_valid && !i_out_stall;

    radix_conversion_digit_emitter_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_value      (i_value),
        .i_base       (i_base),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_digit_char (o_digit_char),
        .o_last       (o_last)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // receiver: random stall, or a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
            holds_done++;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_xfer) sb.check_digit(o_digit_char, o_last);
    end

    initial begin
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || in_xfer || out_xfer) quiet = 0;
            else quiet++;
        end
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("** radix_conversion_digit_emitter_unit: FAILED **");
        $finish;
    end

    task offer_item(logic [VW-1:0] v, logic [RW-1:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_value    <= v;
        i_base     <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_conversion(v, b);
        items_sent++;
    endtask

    // stop offering until every expected digit has come out
    task drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        logic [VW-1:0] v;
        logic [RW-1:0] b;
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero, extremes, clamped radices, all glyphs
        offer_item(32'h0000_0000, 5'd2);
        offer_item(32'h0000_0000, 5'd10);
        offer_item(32'h0000_0000, 5'd16);
        offer_item(32'hFFFF_FFFF, 5'd2);
        offer_item(32'hFFFF_FFFF, 5'd10);
        offer_item(32'hFFFF_FFFF, 5'd16);
        offer_item(32'h8000_0000, 5'd2);
        offer_item(32'h0000_0001, 5'd2);
        offer_item(32'h0000_0010, 5'd16);
        offer_item(32'h0000_00FF, 5'd16);
        offer_item(32'h0123_4567, 5'd16);
        offer_item(32'h89AB_CDEF, 5'd16);
        offer_item(32'd1234567890, 5'd10);
        offer_item(32'h0000_002D, 5'd0);
        offer_item(32'h0000_002D, 5'd1);
        offer_item(32'hDEAD_BEEF, 5'd17);
        offer_item(32'hDEAD_BEEF, 5'd31);
        offer_item(32'hFFFF_FFFF, 5'd3);
        offer_item(32'h7FFF_FFFF, 5'd7);
        offer_item(32'd224, 5'd15);
        offer_item(32'd12, 5'd12);
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 64; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 64; end
                default: begin send_idle_pct = 37; stall_pct = 37; end
            endcase
            for (int n = 0; n < ITEMS_PER_PASS; n++) begin
                if (phase == 1 && n == 20) hold_req = 1'b1;
                case ($urandom_range(9))
                    0, 1, 2, 3: v = $urandom;
                    4, 5, 6:    v = $urandom & ((32'd1 << $urandom_range(16)) - 32'd1);
                    7:          v = $urandom_range(15);
                    8: begin
                        case ($urandom_range(2))
                            0:       v = '0;
                            1:       v = '1;
                            default: v = 32'd1 << $urandom_range(31);
                        endcase
                    end
                    default:    v = $urandom >> $urandom_range(31);
                endcase
                if ($urandom_range(9) < 8) b = RW'($urandom_range(16, 2));
                else                       b = RW'($urandom_range(31));
                offer_item(v, b);
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("run: %0d conversions (zero, extremes, clamped radices, random mix) -> %0d digits",
                 items_sent, sb.checked);
        $display("run: four idle/stall mixes, %0d long receiver hold-off(s), drains between phases",
                 holds_done);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("** radix_conversion_digit_emitter_unit: PASSED **");
        end else begin
            $display("** radix_conversion_digit_emitter_unit: FAILED **");
        end
        $finish;
    end

endmodule
